>>> sv/gf128_dot_product_accumulate_core_macros.svh
// Assertion macros shared by the dot product core.
`ifndef GF128_DOT_PRODUCT_ACCUMULATE_CORE_MACROS_SVH
`define GF128_DOT_PRODUCT_ACCUMULATE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define GDPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define GDPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gdpa_pkg.sv
// Types, constants and the carry-less multiply function of the dot product core.
`timescale 1ns / 1ps
package gdpa_pkg;

  // One input pair with its end-of-vector controls.
  typedef struct packed {
    logic [63:0] x_low;
    logic [63:0] x_high;
    logic [63:0] y_low;
    logic [63:0] y_high;
    logic        last;
    logic        accumulate;
    logic [63:0] prior_low;
    logic [63:0] prior_high;
  } item_t;

  // Engine sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROD,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Three products, each split in two 64x32 halves.
  localparam logic [2:0] LAST_STEP = 3'd5;

  // Product selectors (upper bits of the step counter).
  localparam logic [1:0] SEL_LOW  = 2'd0;
  localparam logic [1:0] SEL_HIGH = 2'd1;
  localparam logic [1:0] SEL_MID  = 2'd2;

  // Fold step at which the low overflow word joins the high result word.
  localparam logic [2:0] OVERFLOW_STEP = 3'd4;

  // Carry-less 64x32 product; every partial term is independent.
  function automatic logic [94:0] clmul64x32(input logic [63:0] a, input logic [31:0] b);
    logic [94:0] acc;
    acc = '0;
    for (int i = 0; i < 32; i++) begin
      if (b[i]) begin
        acc = acc ^ ({31'b0, a} << i);
      end
    end
    return acc;
  endfunction

endpackage

>>> sv/gdpa_queue.sv
// Two-entry item queue between the input channel and the engine.
`timescale 1ns / 1ps
module gdpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gdpa_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output gdpa_pkg::item_t head_item
);
  import gdpa_pkg::*;

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

  // Item storage; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> sv/gdpa_engine.sv
// Sequenced Karatsuba accumulation, two-fold reduction and result register.
`timescale 1ns / 1ps
module gdpa_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic [63:0]     poly,
  input  logic            head_valid,
  input  gdpa_pkg::item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [63:0]     sum_low,
  output logic [63:0]     sum_high
);
  import gdpa_pkg::*;

  state_t       state;
  state_t       state_next;
  logic [2:0]   step;
  item_t        cur;
  logic [127:0] low_product_sum;
  logic [127:0] high_product_sum;
  logic [127:0] middle_product_sum;
  logic [127:0] e_reg;
  logic [127:0] u_reg;

  logic         prod_en;
  logic         fold_en;
  logic         emit_fire;
  logic         step_done;
  logic [1:0]   sel;
  logic [63:0]  op_a;
  logic [31:0]  op_b;
  logic [63:0]  x_sel;
  logic [63:0]  y_sel;
  logic [94:0]  prod;
  logic [127:0] prod_ext;
  logic [127:0] prod_sh;
  logic [127:0] d_word;
  logic [63:0]  c_high;
  logic [63:0]  c_low;
  logic [127:0] u_base;
  logic [127:0] result;

  assign sel       = step[2:1];
  assign step_done = (step == LAST_STEP);

  // Control outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    prod_en   = 1'b0;
    fold_en   = 1'b0;
    emit_fire = 1'b0;
    unique case (state)
      ST_IDLE: pop       = head_valid;
      ST_PROD: prod_en   = 1'b1;
      ST_FOLD: fold_en   = 1'b1;
      ST_EMIT: emit_fire = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head_valid) state_next = ST_PROD;
      ST_PROD: begin
        if (step_done) begin
          state_next = cur.last ? ST_FOLD : ST_IDLE;
        end
      end
      ST_FOLD: if (step_done) state_next = ST_EMIT;
      ST_EMIT: if (emit_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Karatsuba form of the accumulators and the high half to be folded.
  assign d_word = middle_product_sum ^ low_product_sum ^ high_product_sum;
  assign u_base = {low_product_sum[127:64] ^ d_word[63:0], low_product_sum[63:0]};
  assign c_high = high_product_sum[127:64];
  assign c_low  = high_product_sum[63:0] ^ d_word[127:64];

  // Operand selection for the shared 64x32 carry-less multiplier.
  always_comb begin
    unique case (sel)
      SEL_LOW: begin
        x_sel = cur.x_low;
        y_sel = cur.y_low;
      end
      SEL_HIGH: begin
        x_sel = cur.x_high;
        y_sel = cur.y_high;
      end
      default: begin
        x_sel = cur.x_low ^ cur.x_high;
        y_sel = cur.y_low ^ cur.y_high;
      end
    endcase
    if (fold_en) begin
      unique case (sel)
        SEL_LOW:  op_a = c_high;
        SEL_HIGH: op_a = c_low;
        default:  op_a = e_reg[127:64];
      endcase
      op_b = step[0] ? poly[63:32] : poly[31:0];
    end else begin
      op_a = x_sel;
      op_b = step[0] ? y_sel[63:32] : y_sel[31:0];
    end
  end

  assign prod     = clmul64x32(op_a, op_b);
  assign prod_ext = {33'b0, prod};
  assign prod_sh  = step[0] ? {prod_ext[95:0], 32'b0} : prod_ext;

  // Final sum with the optional prior value.
  assign result = u_base ^ u_reg
                ^ (cur.accumulate ? {cur.prior_high, cur.prior_low} : 128'b0);

  // Sequencer state and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      if (prod_en || fold_en) begin
        step <= step_done ? 3'd0 : step + 3'd1;
      end
    end
  end

  // Current item register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_item;
    end
  end

  // Unreduced accumulators; cleared when a result is written out.
  always_ff @(posedge clk) begin
    if (rst || emit_fire) begin
      low_product_sum    <= '0;
      high_product_sum   <= '0;
      middle_product_sum <= '0;
    end else if (prod_en) begin
      unique case (sel)
        SEL_LOW:  low_product_sum    <= low_product_sum ^ prod_sh;
        SEL_HIGH: high_product_sum   <= high_product_sum ^ prod_sh;
        default:  middle_product_sum <= middle_product_sum ^ prod_sh;
      endcase
    end
  end

  // Fold registers: overflow product and folded contributions.
  always_ff @(posedge clk) begin
    if (fold_en) begin
      priority if (step == 3'd0) begin
        e_reg <= prod_sh;
        u_reg <= '0;
      end else if (sel == SEL_LOW) begin
        e_reg <= e_reg ^ prod_sh;
      end else if (step == OVERFLOW_STEP) begin
        u_reg <= u_reg ^ prod_sh ^ {e_reg[63:0], 64'b0};
      end else begin
        u_reg <= u_reg ^ prod_sh;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      sum_low  <= result[63:0];
      sum_high <= result[127:64];
    end
  end

endmodule

>>> sv/gf128_dot_product_accumulate_core.sv
// Top level of the GF(2^128) Karatsuba dot product and accumulate core.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  x_low x_high y_low y_high last accumulate
//                                            prior_low prior_high
//   out      output     out_valid/out_stall  sum_low sum_high
//   cfg      input      cfg_we               cfg_data (reduction polynomial low word)
//
// Each item is loaded from the queue and then runs three 64x64 carry-less products,
// each done as two passes through one shared 64x32 multiplier.
// The last item of a vector adds a fold phase and a result write.
// A two-entry queue takes items while the engine works or a result waits on out_stall.
// Synchronous reset empties the queue, clears the accumulators and sets the word to 0x87.
`timescale 1ns / 1ps
`include "gf128_dot_product_accumulate_core_macros.svh"
module gf128_dot_product_accumulate_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] x_low,
  input  logic [63:0] x_high,
  input  logic [63:0] y_low,
  input  logic [63:0] y_high,
  input  logic        last,
  input  logic        accumulate,
  input  logic [63:0] prior_low,
  input  logic [63:0] prior_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] sum_low,
  output logic [63:0] sum_high
);
  import gdpa_pkg::*;

  logic [63:0] poly;
  item_t       in_item;
  item_t       head_item;
  logic        push;
  logic        pop;
  logic        head_valid;
  logic        full;

  // Reduction polynomial register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= 64'h87;
    end else if (cfg_we) begin
      poly <= cfg_data;
    end
  end

  // Pack one input transfer.
  always_comb begin
    in_item.x_low      = x_low;
    in_item.x_high     = x_high;
    in_item.y_low      = y_low;
    in_item.y_high     = y_high;
    in_item.last       = last;
    in_item.accumulate = accumulate;
    in_item.prior_low  = prior_low;
    in_item.prior_high = prior_high;
  end

  assign in_stall = full;
  assign push     = in_valid && !full;

  gdpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (in_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  gdpa_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .poly       (poly),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sum_low    (sum_low),
    .sum_high   (sum_high)
  );

  // A full queue always has an item at its head.
  `GDPA_ASSERT_IMPL(a_full_has_head, full, head_valid, "full queue without a head item")
  // The engine only takes an item that the queue holds.
  `GDPA_ASSERT_IMPL(a_pop_valid, pop, head_valid, "engine popped an empty queue")
  // A transfer into an empty queue shows up at its head next cycle.
  `GDPA_ASSERT_NEXT(a_push_visible, push && !head_valid, head_valid, "pushed item lost")

endmodule
